/* rtl/dov_pkg.sv */
`timescale 1ns / 1ps

package dov_pkg;

  localparam int NUM_SENSORS = 8;
  localparam int DEPTH       = 8;

  localparam int SENSOR_W    = 3;
  localparam int DIST_W      = 10;
  localparam int PCT_W       = 7;
  localparam int SMP_W       = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 10;

  localparam int SLOT_W      = $clog2(DEPTH);
  localparam int NUM_ENTRIES = NUM_SENSORS * DEPTH;
  localparam int ADDR_W      = $clog2(NUM_ENTRIES);

  localparam int PCT_BASE    = 100;
  localparam int PROD_W      = 18;

  localparam logic [DIST_W-1:0] MAXD_RESET   = DIST_W'(200);
  localparam logic [PCT_W-1:0]  PCT_RESET    = PCT_W'(10);
  localparam logic [SMP_W-1:0]  SAMPLES_RESET = SMP_W'(3);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_DISTANCE       = 3'd0,
    CFG_DEFAULT_ERROR_PCT  = 3'd1,
    CFG_DEFAULT_SAMPLES    = 3'd2,
    CFG_MAX_DIST_ERROR_PCT = 3'd3,
    CFG_MAX_DIST_SAMPLES   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [SENSOR_W-1:0] sensor;
    logic [DIST_W-1:0]   distance;
    logic                advance;
  } dov_in_t;

  typedef struct packed {
    logic [DIST_W-1:0] validated_distance;
    logic              accepted;
  } dov_out_t;

endpackage

/* rtl/distance_outlier_validator_unit.sv */
`timescale 1ns / 1ps

// Distance outlier validator.
// Input channel (in_valid_i / in_stall_o) takes one item per reading: sensor index,
// distance and a flag that first advances the shared sample slot. Output channel
// (out_valid_o / out_stall_i) gives one item per input item: the validated distance
// and whether the new reading was taken. Registers are written through the cfg
// channel (cfg_valid_i / cfg_ready_o, always ready); the user must write them only
// while the block is idle, which the block does not enforce. A reading goes through
// S_RDPREV, S_MUL, S_BAND, S_WALK (out of band only: at most DEPTH-1 = 7 earlier raw
// samples) and S_DONE, which loads the output register; a sensor index out of range
// goes straight to S_DONE. The next item can be taken in the cycle after the result
// is loaded. The walk reads the raw sample RAM through its single read port, one
// sample a cycle. Reset: registers return to their defaults, the slot to DEPTH-1,
// and all sample entries read as 200 until written (per-entry valid bits).
// A stalled receiver holds the result in the output register; the block accepts
// one more item, then waits with its result until the output register drains.
module distance_outlier_validator_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  dov_pkg::dov_in_t           in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output dov_pkg::dov_out_t          out_data_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [dov_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dov_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import dov_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDPREV,
    S_MUL,
    S_BAND,
    S_WALK,
    S_DONE
  } state_e;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] k);
    return (k == SLOT_W'(DEPTH - 1)) ? '0 : SLOT_W'(k + 1'b1);
  endfunction

  function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] k);
    return (k == '0) ? SLOT_W'(DEPTH - 1) : SLOT_W'(k - 1'b1);
  endfunction

  function automatic logic [ADDR_W-1:0] entry_addr(input logic [SENSOR_W-1:0] s,
                                                   input logic [SLOT_W-1:0] k);
    int a;
    a = int'(s) * DEPTH + int'(k);
    return ADDR_W'(a);
  endfunction

  function automatic logic [PROD_W-1:0] x100(input logic [DIST_W-1:0] v);
    return PROD_W'(PROD_W'(v) * PROD_W'(PCT_BASE));
  endfunction

  // configuration
  logic [DIST_W-1:0] max_distance_q;
  logic [PCT_W-1:0]  default_error_pct_q;
  logic [SMP_W-1:0]  default_samples_q;
  logic [PCT_W-1:0]  max_dist_error_pct_q;
  logic [SMP_W-1:0]  max_dist_samples_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_distance_q       <= MAXD_RESET;
      default_error_pct_q  <= PCT_RESET;
      default_samples_q    <= SAMPLES_RESET;
      max_dist_error_pct_q <= PCT_RESET;
      max_dist_samples_q   <= SAMPLES_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_MAX_DISTANCE:       max_distance_q       <= cfg_data_i[DIST_W-1:0];
        CFG_DEFAULT_ERROR_PCT:  default_error_pct_q  <= cfg_data_i[PCT_W-1:0];
        CFG_DEFAULT_SAMPLES:    default_samples_q    <= cfg_data_i[SMP_W-1:0];
        CFG_MAX_DIST_ERROR_PCT: max_dist_error_pct_q <= cfg_data_i[PCT_W-1:0];
        CFG_MAX_DIST_SAMPLES:   max_dist_samples_q   <= cfg_data_i[SMP_W-1:0];
        default: ;
      endcase
    end
  end

  // datapath state
  state_e              state_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [SLOT_W-1:0]   cur_q;
  logic [SLOT_W-1:0]   prev_slot_q;
  logic [SLOT_W-1:0]   idx_q;
  logic [SLOT_W-1:0]   count_q;
  logic [SENSOR_W-1:0] sensor_q;
  logic [DIST_W-1:0]   dist_q;
  logic [DIST_W-1:0]   prev_q;
  logic [PCT_W-1:0]    pct_q;
  logic [SMP_W-1:0]    need_m1_q;
  logic [PROD_W-1:0]   hi_q;
  logic [PROD_W-1:0]   lo_q;
  logic                below_q;
  logic                take_q;
  logic                inrange_q;
  logic                rd_vld_q;
  logic [NUM_ENTRIES-1:0] vld_q;
  logic                out_valid_q;
  dov_out_t            out_q;

  // memories
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic              ram_we;
  logic [DIST_W-1:0] raw_rdata;
  logic [DIST_W-1:0] val_rdata;
  logic [DIST_W-1:0] result;

  dov_ram #(.WIDTH(DIST_W), .DEPTH(NUM_ENTRIES)) u_raw_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_addr),
    .wdata_i (dist_q),
    .raddr_i (rd_addr),
    .rdata_o (raw_rdata)
  );

  dov_ram #(.WIDTH(DIST_W), .DEPTH(NUM_ENTRIES)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_addr),
    .wdata_i (result),
    .raddr_i (rd_addr),
    .rdata_o (val_rdata)
  );

  // combinational helpers
  logic              accept;
  logic              out_free;
  logic [SLOT_W-1:0] cur_d;
  logic              is_max;
  logic [PCT_W-1:0]  pct_sel;
  logic [SMP_W-1:0]  need_sel;
  logic [DIST_W-1:0] prev_rd;
  logic [DIST_W-1:0] sample;
  logic [PROD_W-1:0] dist_s;
  logic [PROD_W-1:0] smp_s;
  logic              dist_in;
  logic              smp_in;
  logic [SLOT_W-1:0] idx_n;
  logic [SLOT_W-1:0] cnt_n;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign cur_d    = in_data_i.advance ? slot_inc(slot_q) : slot_q;
  assign is_max   = in_data_i.distance == max_distance_q;
  assign pct_sel  = is_max ? max_dist_error_pct_q : default_error_pct_q;
  assign need_sel = is_max ? max_dist_samples_q : default_samples_q;
  assign prev_rd  = rd_vld_q ? val_rdata : MAXD_RESET;
  assign sample   = rd_vld_q ? raw_rdata : MAXD_RESET;

  // v <= floor(h/100) <=> 100v <= h ; v >= floor(l/100) <=> 100(v+1) > l
  assign dist_s  = x100(dist_q);
  assign smp_s   = x100(sample);
  assign dist_in = (dist_s <= hi_q) && (PROD_W'(dist_s + PROD_W'(PCT_BASE)) > lo_q);
  assign smp_in  = below_q ? ((sample <= prev_q) &&
                              (PROD_W'(smp_s + PROD_W'(PCT_BASE)) > lo_q))
                           : ((sample >= prev_q) && (smp_s <= hi_q));
  assign idx_n   = slot_dec(idx_q);
  assign cnt_n   = SLOT_W'(count_q + 1'b1);

  always_comb begin
    case (state_q)
      S_WALK:  rd_addr = entry_addr(sensor_q, idx_n);
      default: rd_addr = entry_addr(sensor_q, prev_slot_q);
    endcase
  end

  assign wr_addr = entry_addr(sensor_q, cur_q);
  assign ram_we  = (state_q == S_DONE) && out_free && inrange_q;
  assign result  = take_q ? dist_q : prev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      slot_q      <= SLOT_W'(DEPTH - 1);
      cur_q       <= '0;
      prev_slot_q <= '0;
      idx_q       <= '0;
      count_q     <= '0;
      sensor_q    <= '0;
      dist_q      <= '0;
      prev_q      <= '0;
      pct_q       <= '0;
      need_m1_q   <= '0;
      hi_q        <= '0;
      lo_q        <= '0;
      below_q     <= 1'b0;
      take_q      <= 1'b0;
      inrange_q   <= 1'b0;
      rd_vld_q    <= 1'b0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      rd_vld_q <= vld_q[rd_addr];
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            slot_q      <= cur_d;
            cur_q       <= cur_d;
            prev_slot_q <= slot_dec(cur_d);
            sensor_q    <= in_data_i.sensor;
            dist_q      <= in_data_i.distance;
            pct_q       <= (int'(pct_sel) > PCT_BASE) ? PCT_W'(PCT_BASE) : pct_sel;
            need_m1_q   <= (need_sel == '0) ? '0 : SMP_W'(need_sel - 1'b1);
            inrange_q   <= int'(in_data_i.sensor) < NUM_SENSORS;
            take_q      <= 1'b0;
            prev_q      <= '0;
            if (int'(in_data_i.sensor) < NUM_SENSORS) begin
              state_q <= S_RDPREV;
            end else begin
              state_q <= S_DONE;
            end
          end
        end
        S_RDPREV: begin
          state_q <= S_MUL;
        end
        S_MUL: begin
          prev_q  <= prev_rd;
          hi_q    <= PROD_W'(PROD_W'(prev_rd) * (PROD_W'(PCT_BASE) + PROD_W'(pct_q)));
          lo_q    <= PROD_W'(PROD_W'(prev_rd) * (PROD_W'(PCT_BASE) - PROD_W'(pct_q)));
          state_q <= S_BAND;
        end
        S_BAND: begin
          below_q <= dist_q < prev_q;
          count_q <= '0;
          idx_q   <= prev_slot_q;
          if (dist_in) begin
            take_q  <= 1'b1;
            state_q <= S_DONE;
          end else begin
            state_q <= S_WALK;
          end
        end
        S_WALK: begin
          if (smp_in) begin
            take_q  <= int'(count_q) >= int'(need_m1_q);
            state_q <= S_DONE;
          end else if (idx_n == cur_q) begin
            take_q  <= int'(cnt_n) >= int'(need_m1_q);
            state_q <= S_DONE;
          end else begin
            count_q <= cnt_n;
            idx_q   <= idx_n;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q                    <= 1'b1;
            out_q.validated_distance       <= result;
            out_q.accepted                 <= take_q;
            if (inrange_q) begin
              vld_q[wr_addr] <= 1'b1;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  ap_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("block not busy after accepting an item");

  ap_walk_not_current : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (idx_q != cur_q))
    else $error("walk reached the current slot");

  ap_walk_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (int'(count_q) < DEPTH - 1))
    else $error("walk count out of range");

  ap_write_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> out_valid_o)
    else $error("store update without a result");
`endif

endmodule

/* rtl/dov_ram.sv */
`timescale 1ns / 1ps

module dov_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* test/dov_validation_monitor.sv */
`timescale 1ns / 1ps

module dov_validation_monitor
  import dov_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  dov_in_t               in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  dov_out_t              out_data_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);

  typedef enum int {BAND_BOTH, BAND_BELOW, BAND_ABOVE} band_e;

  logic [DIST_W-1:0] raw_hist [NUM_SENSORS][DEPTH];
  logic [DIST_W-1:0] vld_hist [NUM_SENSORS][DEPTH];
  int unsigned       slot;
  logic [DIST_W-1:0] maxd;
  logic [PCT_W-1:0]  def_pct;
  logic [PCT_W-1:0]  maxd_pct;
  logic [SMP_W-1:0]  def_need;
  logic [SMP_W-1:0]  maxd_need;
  dov_out_t          validated_q[$];
  int unsigned       fails;

  function automatic bit in_band(int unsigned ref_d, int unsigned d, int unsigned pct,
                                 band_e side);
    int unsigned hi;
    int unsigned lo;
    hi = (side == BAND_BELOW) ? ref_d : ref_d * (PCT_BASE + pct) / PCT_BASE;
    lo = (side == BAND_ABOVE) ? ref_d : ref_d * (PCT_BASE - pct) / PCT_BASE;
    return (d <= hi) && (d >= lo);
  endfunction

  function automatic dov_out_t validate_reading(dov_in_t item);
    int unsigned s;
    int unsigned d;
    int unsigned pct;
    int unsigned need;
    int unsigned prev_slot;
    int unsigned prev;
    int unsigned idx;
    int unsigned run;
    band_e       side;
    bit          take;
    dov_out_t    res;
    s = item.sensor;
    d = item.distance;
    res = '0;
    if (item.advance) slot = (slot + 1) % DEPTH;
    if (s >= NUM_SENSORS) return res;
    raw_hist[s][slot] = item.distance;
    if (item.distance == maxd) begin
      pct = maxd_pct;
      need = maxd_need;
    end else begin
      pct = def_pct;
      need = def_need;
    end
    if (pct > PCT_BASE) pct = PCT_BASE;
    if (need == 0) need = 1;
    prev_slot = (slot + DEPTH - 1) % DEPTH;
    prev = vld_hist[s][prev_slot];
    if (in_band(prev, d, pct, BAND_BOTH)) begin
      take = 1'b1;
    end else begin
      // count consecutive older samples lying outside the band on the new value's side
      side = (d < prev) ? BAND_BELOW : BAND_ABOVE;
      run = 0;
      idx = prev_slot;
      while (idx != slot && !in_band(prev, raw_hist[s][idx], pct, side)) begin
        run++;
        idx = (idx + DEPTH - 1) % DEPTH;
      end
      take = (run >= need - 1);
    end
    res.validated_distance = take ? item.distance : DIST_W'(prev);
    res.accepted = take;
    vld_hist[s][slot] = res.validated_distance;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    dov_out_t want;
    if (!rst_ni) begin
      for (int s = 0; s < NUM_SENSORS; s++) begin
        for (int k = 0; k < DEPTH; k++) begin
          raw_hist[s][k] = MAXD_RESET;
          vld_hist[s][k] = MAXD_RESET;
        end
      end
      slot = DEPTH - 1;
      maxd = MAXD_RESET;
      def_pct = PCT_RESET;
      maxd_pct = PCT_RESET;
      def_need = SAMPLES_RESET;
      maxd_need = SAMPLES_RESET;
      validated_q.delete();
      fails = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_MAX_DISTANCE:       maxd = cfg_data_i[DIST_W-1:0];
          CFG_DEFAULT_ERROR_PCT:  def_pct = cfg_data_i[PCT_W-1:0];
          CFG_DEFAULT_SAMPLES:    def_need = cfg_data_i[SMP_W-1:0];
          CFG_MAX_DIST_ERROR_PCT: maxd_pct = cfg_data_i[PCT_W-1:0];
          CFG_MAX_DIST_SAMPLES:   maxd_need = cfg_data_i[SMP_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (validated_q.size() == 0) begin
          $display("%0t: unexpected item: expected none, actual distance %0d accepted %0b",
                   $time, out_data_i.validated_distance, out_data_i.accepted);
          fails++;
        end else begin
          want = validated_q.pop_front();
          if (out_data_i.validated_distance !== want.validated_distance) begin
            $display("%0t: validated_distance mismatch: expected %0d, actual %0d",
                     $time, want.validated_distance, out_data_i.validated_distance);
            fails++;
          end
          if (out_data_i.accepted !== want.accepted) begin
            $display("%0t: accepted mismatch: expected %0b, actual %0b",
                     $time, want.accepted, out_data_i.accepted);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) validated_q.push_back(validate_reading(in_data_i));
    end
    fail_count_o <= fails;
    pending_o <= validated_q.size();
  end

endmodule

/* test/distance_outlier_validator_unit_tb.sv */
`timescale 1ns / 1ps

module distance_outlier_validator_unit_tb;
  import dov_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 120;
  localparam int unsigned DRAIN_CYCLES   = 20;

  typedef enum int {RX_FREE, RX_HALF, RX_LIGHT, RX_HEAVY} stall_mode_e;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  dov_in_t               in_data;
  logic                  out_valid;
  logic                  out_stall;
  dov_out_t              out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int unsigned           fail_count;
  int unsigned           pending;

  logic [DIST_W-1:0]     level [NUM_SENSORS];
  logic [DIST_W-1:0]     cur_maxd;
  int unsigned           cur_dpct;
  int unsigned           burst_left;
  bit                    pressure_armed;

  distance_outlier_validator_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  dov_validation_monitor monitor (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic dov_in_t reading(int unsigned s, int unsigned d, int unsigned adv);
    dov_in_t item;
    item.sensor = SENSOR_W'(s);
    item.distance = DIST_W'(d);
    item.advance = adv[0];
    return item;
  endfunction

  // mostly noise around a per-sensor level, with lasting steps, spikes and no-echo readings
  function automatic logic [DIST_W-1:0] next_distance(int unsigned s);
    int unsigned pick;
    int          spread;
    int          d;
    if ($urandom_range(0, 99) < 8)
      level[s] = ($urandom_range(0, 3) == 0) ? cur_maxd : DIST_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 12) return cur_maxd;
    if (pick < 24) return DIST_W'($urandom);
    spread = int'(level[s]) * int'($urandom_range(0, 2 * cur_dpct + 1)) / 100;
    d = ($urandom_range(0, 1) == 1) ? int'(level[s]) + spread : int'(level[s]) - spread;
    if (d < 0) d = 0;
    if (d > (1 << DIST_W) - 1) d = (1 << DIST_W) - 1;
    return DIST_W'(d);
  endfunction

  task automatic send_reading(input dov_in_t item);
    in_data <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_e reg_sel, input int unsigned value);
    cfg_index <= reg_sel;
    cfg_data <= CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic program_regs(input int unsigned maxd, input int unsigned dpct,
                              input int unsigned dsmp, input int unsigned mpct,
                              input int unsigned msmp);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_write(CFG_MAX_DISTANCE, maxd);
    cfg_write(CFG_DEFAULT_ERROR_PCT, dpct);
    cfg_write(CFG_DEFAULT_SAMPLES, dsmp);
    cfg_write(CFG_MAX_DIST_ERROR_PCT, mpct);
    cfg_write(CFG_MAX_DIST_SAMPLES, msmp);
    cfg_valid <= 1'b0;
    cur_maxd = DIST_W'(maxd);
    cur_dpct = dpct;
  endtask

  // rounds over a small group of neighboring sensors, the first of each round mostly advancing the slot
  task automatic run_rounds(input int unsigned n_items);
    int unsigned sent;
    int unsigned first;
    int unsigned width;
    int unsigned s;
    dov_in_t     item;
    sent = 0;
    first = $urandom_range(0, NUM_SENSORS - 1);
    width = $urandom_range(1, 3);
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 15) begin
        item.sensor = SENSOR_W'($urandom);
        item.distance = DIST_W'($urandom);
        item.advance = 1'($urandom_range(0, 1));
        send_reading(item);
        sent++;
      end else begin
        for (int k = 0; k < width; k++) begin
          s = (first + k) % NUM_SENSORS;
          item.sensor = SENSOR_W'(s);
          item.distance = next_distance(s);
          item.advance = (k == 0) && ($urandom_range(0, 9) != 0);
          send_reading(item);
          sent++;
        end
      end
    end
  endtask

  initial begin : receiver
    stall_mode_e mode;
    int unsigned len;
    out_stall = 1'b0;
    forever begin
      mode = stall_mode_e'($urandom_range(0, 3));
      len = $urandom_range(5, 60);
      repeat (len) begin
        @(negedge clk);
        case (mode)
          RX_FREE:  out_stall <= 1'b0;
          RX_HALF:  out_stall <= ($urandom_range(0, 1) == 1);
          RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          default:  out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
      if (pressure_armed) begin
        pressure_armed = 1'b0;
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("distance_outlier_validator_unit verification failed");
    $finish;
  end

  initial begin : stimulus
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MAX_DISTANCE;
    cfg_data = '0;
    rst_n = 1'b0;
    pressure_armed = 1'b0;
    burst_left = 0;
    cur_maxd = MAXD_RESET;
    cur_dpct = int'(PCT_RESET);
    for (int i = 0; i < NUM_SENSORS; i++) level[i] = MAXD_RESET;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: band edges, steps held then taken, no-echo readings, field extremes
    send_reading(reading(0, 200, 0));
    send_reading(reading(7, 1023, 1));
    send_reading(reading(7, 1023, 1));
    send_reading(reading(7, 1023, 1));
    send_reading(reading(3, 0, 1));
    send_reading(reading(3, 0, 1));
    send_reading(reading(3, 0, 1));
    send_reading(reading(0, 200, 1));
    send_reading(reading(0, 220, 0));
    send_reading(reading(0, 221, 0));
    send_reading(reading(0, 180, 0));
    send_reading(reading(0, 179, 0));
    send_reading(reading(5, 200, 1));
    send_reading(reading(5, 1023, 1));
    send_reading(reading(5, 0, 1));
    send_reading(reading(5, 1023, 1));
    send_reading(reading(1, 512, 1));
    send_reading(reading(2, 341, 1));
    send_reading(reading(4, 682, 1));
    send_reading(reading(6, 1, 1));
    send_reading(reading(1, 512, 1));
    send_reading(reading(1, 512, 0));
    run_rounds(110);

    program_regs(1023, 0, 1, 0, 1);
    run_rounds(130);

    // percent above 100, unreachable sample count, zero sample count
    program_regs(1, 127, 15, 100, 0);
    run_rounds(130);

    program_regs($urandom_range(1, 1023), $urandom_range(0, 127), $urandom_range(0, 15),
                 $urandom_range(0, 127), $urandom_range(0, 15));
    pressure_armed = 1'b1;
    run_rounds(140);

    program_regs(400, 20, 4, 5, 8);
    run_rounds(140);

    program_regs(200, 10, 8, 100, 2);
    run_rounds(130);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("distance_outlier_validator_unit verification clean");
    else
      $display("distance_outlier_validator_unit verification failed");
    $finish;
  end

endmodule
